// ===== rtl/core/ips_pkg.sv =====
// Shared types, widths and codes for the interval profiler.
// No dependencies; imported by every module of the block.
package ips_pkg;

    localparam int unsigned STAMP_W       = 32;
    localparam int unsigned MICROS_W      = 32;
    localparam int unsigned TOTAL_W       = 48;
    localparam int unsigned COUNT_W       = 32;
    localparam int unsigned MEAN_W        = 40;
    localparam int unsigned CLK_MHZ_W     = 10;
    localparam int unsigned OP_W          = 2;
    localparam int unsigned CHAN_W        = 2;

    localparam int unsigned DEF_CHANNELS  = 3;
    localparam int unsigned DEF_FRAC_BITS = 8;

    localparam logic [CLK_MHZ_W-1:0] CLOCK_MHZ_RESET = 10'd168;
    localparam logic [CHAN_W-1:0]    TOTAL_CHANNEL   = 2'd2;

    localparam logic [OP_W-1:0] OP_START  = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP   = 2'd1;
    localparam logic [OP_W-1:0] OP_REPORT = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic KIND_STOP   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Write strobes from the sequencer into the statistics bank.
    typedef struct packed {
        logic clear;
        logic start_we;
        logic stop_we;
        logic mean_we;
    } t_bank_ctl;

    // Statistics of the addressed channel plus the shared stop counter.
    typedef struct packed {
        logic [MICROS_W-1:0] min_us;
        logic [MICROS_W-1:0] max_us;
        logic [TOTAL_W-1:0]  total_sum;
        logic [COUNT_W-1:0]  count;
        logic [MEAN_W-1:0]   mean_q;
        logic [COUNT_W-1:0]  stop_total;
    } t_stats;

endpackage

// ===== rtl/core/ips_serial_div.sv =====
// Restoring divider producing one quotient bit per cycle.
// Depends on ips_pkg (imported for house consistency).
module ips_serial_div #(
    parameter int unsigned NUM_W = 56,
    parameter int unsigned DEN_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    import ips_pkg::*;

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num, n_num;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_shift;
    logic             w_ge;
    logic [DEN_W:0]   w_diff;

    // Bring down the next dividend bit, trial-subtract the divisor.
    always_comb begin
        w_shift = {r_rem, r_num[NUM_W-1]};
        w_ge    = (w_shift >= {1'b0, r_den});
        w_diff  = w_shift - {1'b0, r_den};
        n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
        n_num   = {r_num[NUM_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_num;

`ifndef NO_ASSERTIONS
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider flags done while still iterating");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a preceding iteration");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt < CNT_W'(NUM_W)))
        else $error("divider step count past dividend width");
`endif

endmodule

// ===== rtl/core/ips_stats_bank.sv =====
// Per-channel start stamps and statistics, with saturating updates.
// Depends on ips_pkg for widths, the control struct and the stats struct.
module ips_stats_bank #(
    parameter int unsigned CHANNELS = 3,
    parameter int unsigned CH_W     = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ips_pkg::t_bank_ctl           i_ctl,
    input  logic [CH_W-1:0]              i_idx,
    input  logic [ips_pkg::STAMP_W-1:0]  i_stamp,
    input  logic [ips_pkg::MICROS_W-1:0] i_us,
    input  logic [ips_pkg::MEAN_W-1:0]   i_mean,
    output logic [ips_pkg::STAMP_W-1:0]  o_start_stamp,
    output ips_pkg::t_stats              o_stats
);
    import ips_pkg::*;

    logic [STAMP_W-1:0]  r_start [CHANNELS];
    logic [MICROS_W-1:0] r_min   [CHANNELS];
    logic [MICROS_W-1:0] r_max   [CHANNELS];
    logic [TOTAL_W-1:0]  r_total [CHANNELS];
    logic [COUNT_W-1:0]  r_count [CHANNELS];
    logic [MEAN_W-1:0]   r_mean  [CHANNELS];
    logic [COUNT_W-1:0]  r_stops;

    logic [TOTAL_W:0]    w_sum;
    logic [TOTAL_W-1:0]  n_total;

    always_comb begin
        w_sum   = {1'b0, r_total[i_idx]} + (TOTAL_W + 1)'(i_us);
        n_total = w_sum[TOTAL_W] ? '1 : w_sum[TOTAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < int'(CHANNELS); c++) begin
                r_start[c] <= '0;
                r_min[c]   <= '1;
                r_max[c]   <= '0;
                r_total[c] <= '0;
                r_count[c] <= '0;
                r_mean[c]  <= '0;
            end
            r_stops <= '0;
        end else begin
            if (i_ctl.clear) begin
                for (int c = 0; c < int'(CHANNELS); c++) begin
                    r_min[c]   <= '1;
                    r_max[c]   <= '0;
                    r_total[c] <= '0;
                    r_count[c] <= '0;
                    r_mean[c]  <= '0;
                end
                r_stops <= '0;
            end
            if (i_ctl.start_we) begin
                r_start[i_idx] <= i_stamp;
            end
            if (i_ctl.stop_we) begin
                if (i_us < r_min[i_idx]) r_min[i_idx] <= i_us;
                if (i_us > r_max[i_idx]) r_max[i_idx] <= i_us;
                r_total[i_idx] <= n_total;
                if (r_count[i_idx] != '1) r_count[i_idx] <= r_count[i_idx] + 1'b1;
                if (i_idx == CH_W'(TOTAL_CHANNEL) && r_stops != '1) begin
                    r_stops <= r_stops + 1'b1;
                end
            end
            if (i_ctl.mean_we) begin
                r_mean[i_idx] <= i_mean;
            end
        end
    end

    always_comb begin
        o_start_stamp       = r_start[i_idx];
        o_stats.min_us      = r_min[i_idx];
        o_stats.max_us      = r_max[i_idx];
        o_stats.total_sum   = r_total[i_idx];
        o_stats.count       = r_count[i_idx];
        o_stats.mean_q      = r_mean[i_idx];
        o_stats.stop_total  = r_stops;
    end

endmodule

// ===== rtl/core/interval_profiler_stats.sv =====
// Top level of the interval profiler: sequencer, output register, config.
// Depends on ips_pkg, ips_serial_div and ips_stats_bank.
//
//  Channel   Direction  Handshake                    Carries
//  --------  ---------  ---------------------------  ------------------------------
//  in        sink       i_in_valid / o_in_ready      operation, channel, cycle_stamp
//  out       source     o_out_valid / i_out_ready    stop result or statistics report
//  cfg       sink       i_cfg_valid / o_cfg_ready    clock_mhz (always ready)
//
//  Start, clear and items on a channel past the last are taken in the idle state.
//  A stop passes through the divide state, where the bit-serial divider retires one
//  quotient bit per cycle over the 48 + FRAC_BITS bit dividend, then the update state;
//  a report with samples only divides; a report on an empty channel goes to the emit state.
//  A finished result waits in the output register; the next item is taken
//  only once the sequencer has handed its result over to that register.
//  Synchronous active-low reset; no clearing pass, all state is flip-flops.
module interval_profiler_stats #(
    parameter int unsigned CHANNELS  = ips_pkg::DEF_CHANNELS,
    parameter int unsigned FRAC_BITS = ips_pkg::DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ips_pkg::OP_W-1:0]      i_operation,
    input  logic [ips_pkg::CHAN_W-1:0]    i_channel,
    input  logic [ips_pkg::STAMP_W-1:0]   i_cycle_stamp,
    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_result_kind,
    output logic [ips_pkg::CHAN_W-1:0]    o_result_channel,
    output logic [ips_pkg::STAMP_W-1:0]   o_span_cycles,
    output logic [ips_pkg::MICROS_W-1:0]  o_elapsed_micros,
    output logic [ips_pkg::MICROS_W-1:0]  o_min_micros,
    output logic [ips_pkg::MICROS_W-1:0]  o_max_micros,
    output logic [ips_pkg::TOTAL_W-1:0]   o_total_micros,
    output logic [ips_pkg::COUNT_W-1:0]   o_sample_count,
    output logic [ips_pkg::MEAN_W-1:0]    o_mean_micros_q8,
    output logic [ips_pkg::COUNT_W-1:0]   o_measurement_total,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ips_pkg::CLK_MHZ_W-1:0] i_cfg_clock_mhz
);
    import ips_pkg::*;

    localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned NUM_W = TOTAL_W + FRAC_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]           r_state;
    logic [CLK_MHZ_W-1:0] r_clock_mhz;
    logic                 r_kind;
    logic [CHAN_W-1:0]    r_chan;
    logic [CH_W-1:0]      r_idx;
    logic [STAMP_W-1:0]   r_cyc;
    logic [MICROS_W-1:0]  r_us;

    logic                 r_out_valid;
    logic                 r_o_kind;
    logic [CHAN_W-1:0]    r_o_chan;
    logic [STAMP_W-1:0]   r_o_cyc;
    logic [MICROS_W-1:0]  r_o_us;
    t_stats               r_o_stats;

    logic                 w_in_acc;
    logic                 w_chan_ok;
    logic [CH_W-1:0]      w_in_idx;
    logic [CH_W-1:0]      w_bank_idx;
    logic [STAMP_W-1:0]   w_start_stamp;
    logic [STAMP_W-1:0]   w_cyc;
    t_stats               w_stats;
    t_bank_ctl            w_ctl;
    logic                 w_div_start;
    logic [NUM_W-1:0]     w_div_num;
    logic [COUNT_W-1:0]   w_div_den;
    logic                 w_div_busy;
    logic                 w_div_done;
    logic [NUM_W-1:0]     w_div_quot;
    logic [MEAN_W-1:0]    w_mean_sat;
    logic                 w_out_load;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_chan_ok   = (32'(i_channel) < CHANNELS);
    assign w_in_idx    = CH_W'(i_channel);
    // Address the bank from the port while idle, from the held channel otherwise.
    assign w_bank_idx  = (r_state == ST_IDLE) ? w_in_idx : r_idx;
    assign w_cyc       = i_cycle_stamp - w_start_stamp;
    assign w_out_load  = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);

    // Saturate the mean quotient to the output width.
    assign w_mean_sat = (|w_div_quot[NUM_W-1:MEAN_W]) ? '1 : w_div_quot[MEAN_W-1:0];

    // Launch the divider: cycles by clock for a stop, scaled total by count
    // for a report on a channel that has samples.
    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = NUM_W'(w_cyc);
        w_div_den   = COUNT_W'(r_clock_mhz);
        if (w_in_acc && w_chan_ok) begin
            unique case (i_operation)
                OP_STOP:   w_div_start = 1'b1;
                OP_REPORT: begin
                    w_div_start = (w_stats.count != '0);
                    w_div_num   = NUM_W'(w_stats.total_sum) << FRAC_BITS;
                    w_div_den   = w_stats.count;
                end
                OP_START, OP_CLEAR: w_div_start = 1'b0;
                default:            w_div_start = 1'b0;
            endcase
        end
    end

    always_comb begin
        w_ctl          = '0;
        w_ctl.clear    = w_in_acc && (i_operation == OP_CLEAR);
        w_ctl.start_we = w_in_acc && w_chan_ok && (i_operation == OP_START);
        w_ctl.stop_we  = (r_state == ST_UPD);
        w_ctl.mean_we  = (r_state == ST_DIV) && w_div_done && (r_kind == KIND_REPORT);
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_mhz <= CLOCK_MHZ_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_clock_mhz <= i_cfg_clock_mhz;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && w_chan_ok) begin
                        if (w_div_start) begin
                            r_state <= ST_DIV;
                        end else if (i_operation == OP_REPORT) begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= (r_kind == KIND_STOP) ? ST_UPD : ST_EMIT;
                    end
                end
                ST_UPD: r_state <= ST_EMIT;
                ST_EMIT: begin
                    if (w_out_load) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Hold the item context while it is in flight.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind <= (i_operation == OP_REPORT) ? KIND_REPORT : KIND_STOP;
            r_chan <= i_channel;
            r_idx  <= w_in_idx;
            r_cyc  <= w_cyc;
        end
        if ((r_state == ST_DIV) && w_div_done) begin
            // A zero clock gives zero microseconds.
            r_us <= (r_clock_mhz == '0) ? '0 : w_div_quot[MICROS_W-1:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_kind  <= r_kind;
            r_o_chan  <= r_chan;
            r_o_cyc   <= (r_kind == KIND_STOP) ? r_cyc : '0;
            r_o_us    <= (r_kind == KIND_STOP) ? r_us : '0;
            r_o_stats <= w_stats;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_result_kind       = r_o_kind;
    assign o_result_channel    = r_o_chan;
    assign o_span_cycles       = r_o_cyc;
    assign o_elapsed_micros    = r_o_us;
    assign o_min_micros        = r_o_stats.min_us;
    assign o_max_micros        = r_o_stats.max_us;
    assign o_total_micros      = r_o_stats.total_sum;
    assign o_sample_count      = r_o_stats.count;
    assign o_mean_micros_q8    = r_o_stats.mean_q;
    assign o_measurement_total = r_o_stats.stop_total;

    ips_serial_div #(
        .NUM_W (NUM_W),
        .DEN_W (COUNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    ips_stats_bank #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_bank (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_idx         (w_bank_idx),
        .i_stamp       (i_cycle_stamp),
        .i_us          (r_us),
        .i_mean        (w_mean_sat),
        .o_start_stamp (w_start_stamp),
        .o_stats       (w_stats)
    );

`ifndef NO_ASSERTIONS
    a_div_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (w_div_busy || w_div_done))
        else $error("waiting on a divider that is not running");
    a_stop_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_chan_ok && i_operation == OP_STOP) |=> (r_state == ST_DIV))
        else $error("accepted stop did not start a division");
    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_out_valid && !i_out_ready) |=> (r_state == ST_EMIT))
        else $error("result dropped while output register is occupied");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for interval_profiler_stats: start/stop/report/clear items
// against a behavioural predictor, with random idling and output back-pressure.
// Depends on ips_pkg and the interval_profiler_stats RTL.
`timescale 1ns / 1ps

module tb_top;
    import ips_pkg::*;

    localparam int unsigned NUM_CH        = DEF_CHANNELS;
    localparam int unsigned FRAC          = DEF_FRAC_BITS;
    localparam int unsigned SETTLE_CYCLES = 80;
    localparam int unsigned CYCLE_LIMIT   = 1_500_000;
    localparam int unsigned HOLD_CYCLES   = 1500;
    localparam int unsigned REPORT_LIMIT  = 10;

    localparam logic [CHAN_W-1:0] CH_FEATURE  = 2'd0;
    localparam logic [CHAN_W-1:0] CH_INFER    = 2'd1;
    localparam logic [CHAN_W-1:0] BAD_CHANNEL = 2'd3;

    typedef struct {
        logic                kind;
        logic [CHAN_W-1:0]   channel;
        logic [STAMP_W-1:0]  cycles;
        logic [MICROS_W-1:0] micros;
        logic [MICROS_W-1:0] min_us;
        logic [MICROS_W-1:0] max_us;
        logic [TOTAL_W-1:0]  total_sum;
        logic [COUNT_W-1:0]  count;
        logic [MEAN_W-1:0]   mean_q8;
        logic [COUNT_W-1:0]  meas_total;
    } t_profile_result;

    // ---------------------------------------------------------------------------------------
    // DUT signals
    // ---------------------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [OP_W-1:0]       i_operation;
    logic [CHAN_W-1:0]     i_channel;
    logic [STAMP_W-1:0]    i_cycle_stamp;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_result_kind;
    logic [CHAN_W-1:0]     o_result_channel;
    logic [STAMP_W-1:0]    o_span_cycles;
    logic [MICROS_W-1:0]   o_elapsed_micros;
    logic [MICROS_W-1:0]   o_min_micros;
    logic [MICROS_W-1:0]   o_max_micros;
    logic [TOTAL_W-1:0]    o_total_micros;
    logic [COUNT_W-1:0]    o_sample_count;
    logic [MEAN_W-1:0]     o_mean_micros_q8;
    logic [COUNT_W-1:0]    o_measurement_total;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CLK_MHZ_W-1:0]  i_cfg_clock_mhz;

    interval_profiler_stats dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_operation         (i_operation),
        .i_channel           (i_channel),
        .i_cycle_stamp       (i_cycle_stamp),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_result_kind       (o_result_kind),
        .o_result_channel    (o_result_channel),
        .o_span_cycles       (o_span_cycles),
        .o_elapsed_micros    (o_elapsed_micros),
        .o_min_micros        (o_min_micros),
        .o_max_micros        (o_max_micros),
        .o_total_micros      (o_total_micros),
        .o_sample_count      (o_sample_count),
        .o_mean_micros_q8    (o_mean_micros_q8),
        .o_measurement_total (o_measurement_total),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_clock_mhz     (i_cfg_clock_mhz)
    );

    // ---------------------------------------------------------------------------------------
    // Predictor state: a private copy of the profiler's statistics and its clock setting
    // ---------------------------------------------------------------------------------------
    logic [STAMP_W-1:0]    st_start [NUM_CH];
    logic [MICROS_W-1:0]   st_min   [NUM_CH];
    logic [MICROS_W-1:0]   st_max   [NUM_CH];
    logic [TOTAL_W-1:0]    st_total [NUM_CH];
    logic [COUNT_W-1:0]    st_count [NUM_CH];
    logic [MEAN_W-1:0]     st_mean  [NUM_CH];
    logic [COUNT_W-1:0]    st_stops;
    logic [CLK_MHZ_W-1:0]  st_clock_mhz;

    t_profile_result pending_results [$];

    // Idling controls for the sender and the receiver
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    logic        rx_hold;

    int unsigned cycle_count;
    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned stop_results;
    int unsigned report_results;
    int unsigned cfg_writes;

    // ---------------------------------------------------------------------------------------
    // Clock and timeout
    // ---------------------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort if the run hangs: a lost result or a stuck handshake ends here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still awaited",
                     cycle_count, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------------------------
    function automatic void clear_model_stats();
        for (int c = 0; c < NUM_CH; c++) begin
            st_min[c]   = '1;
            st_max[c]   = '0;
            st_total[c] = '0;
            st_count[c] = '0;
            st_mean[c]  = '0;
        end
        st_stops = '0;
    endfunction

    function automatic t_profile_result build_result(input logic kind,
                                                     input logic [CHAN_W-1:0] ch,
                                                     input logic [STAMP_W-1:0] cyc,
                                                     input logic [MICROS_W-1:0] us);
        t_profile_result r;
        r.kind       = kind;
        r.channel    = ch;
        r.cycles     = cyc;
        r.micros     = us;
        r.min_us     = st_min[ch];
        r.max_us     = st_max[ch];
        r.total_sum  = st_total[ch];
        r.count      = st_count[ch];
        r.mean_q8    = st_mean[ch];
        r.meas_total = st_stops;
        return r;
    endfunction

    // Fold one accepted item into the predicted statistics; queue any result it causes
    task automatic compute_profile_result(input logic [OP_W-1:0] op,
                                          input logic [CHAN_W-1:0] ch,
                                          input logic [STAMP_W-1:0] stamp);
        logic [STAMP_W-1:0]  cyc;
        logic [MICROS_W-1:0] us;
        logic [TOTAL_W:0]    sum;
        logic [63:0]         num;
        logic [63:0]         quo;
        if (op == OP_CLEAR) begin
            // clear ignores the channel, even one past the last
            clear_model_stats();
        end else if (ch < NUM_CH) begin
            case (op)
                OP_START: begin
                    st_start[ch] = stamp;
                end
                OP_STOP: begin
                    cyc = stamp - st_start[ch];
                    us  = (st_clock_mhz != '0) ? cyc / st_clock_mhz : '0;
                    if (us < st_min[ch]) st_min[ch] = us;
                    if (us > st_max[ch]) st_max[ch] = us;
                    sum = {1'b0, st_total[ch]} + us;
                    st_total[ch] = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                    if (st_count[ch] != '1) st_count[ch] = st_count[ch] + 1;
                    if (ch == TOTAL_CHANNEL && st_stops != '1) st_stops = st_stops + 1;
                    pending_results.push_back(build_result(KIND_STOP, ch, cyc, us));
                end
                OP_REPORT: begin
                    // an empty channel keeps its previous mean
                    if (st_count[ch] != '0) begin
                        num = 64'(st_total[ch]) << FRAC;
                        quo = num / 64'(st_count[ch]);
                        st_mean[ch] = (quo[63:MEAN_W] != '0) ? '1 : quo[MEAN_W-1:0];
                    end
                    pending_results.push_back(build_result(KIND_REPORT, ch, '0, '0));
                end
                default: ;
            endcase
        end
    endtask

    // ---------------------------------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            if (mismatches < REPORT_LIMIT)
                $display("Mismatch at cycle %0d on %s: expected 0x%0h, got 0x%0h",
                         cycle_count, name, want, got);
            mismatches++;
        end
    endtask

    // Compare each accepted result with the oldest prediction, field by field
    always @(posedge i_clk) begin : result_check
        t_profile_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (o_result_kind == KIND_REPORT) report_results++;
            else stop_results++;
            if (pending_results.size() == 0) begin
                if (mismatches < REPORT_LIMIT)
                    $display("Unexpected result at cycle %0d: kind %0d channel %0d",
                             cycle_count, o_result_kind, o_result_channel);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind",       want.kind,       o_result_kind);
                check_field("result_channel",    want.channel,    o_result_channel);
                check_field("span_cycles",       want.cycles,     o_span_cycles);
                check_field("elapsed_micros",    want.micros,     o_elapsed_micros);
                check_field("min_micros",        want.min_us,     o_min_micros);
                check_field("max_micros",        want.max_us,     o_max_micros);
                check_field("total_micros",      want.total_sum,  o_total_micros);
                check_field("sample_count",      want.count,      o_sample_count);
                check_field("mean_micros_q8",    want.mean_q8,    o_mean_micros_q8);
                check_field("measurement_total", want.meas_total, o_measurement_total);
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // Receiver: random ready, or held low for a long stretch while rx_hold is set
    // ---------------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || rx_hold)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Hold off the receiver through rx_hold for the stall length given by n, counted here
    task automatic hold_receiver(input int unsigned n);
        rx_hold <= 1'b1;
        repeat (n) @(posedge i_clk);
        rx_hold <= 1'b0;
    endtask

    // ---------------------------------------------------------------------------------------
    // Sender and configuration
    // ---------------------------------------------------------------------------------------
    // Offer one item, idling first at random; valid stays high until accepted
    task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] ch,
                             input logic [STAMP_W-1:0] stamp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_channel     <= ch;
        i_cycle_stamp <= stamp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        compute_profile_result(op, ch, stamp);
    endtask

    // Drop valid, wait for every prediction to be met, then let trailing items finish
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_clock_mhz(input logic [CLK_MHZ_W-1:0] mhz);
        settle_block();
        i_cfg_valid     <= 1'b1;
        i_cfg_clock_mhz <= mhz;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid  <= 1'b0;
        st_clock_mhz = mhz;
        cfg_writes++;
    endtask

    function automatic logic [STAMP_W-1:0] random_span();
        case ($urandom_range(3))
            0:       return $urandom_range(255);
            1:       return $urandom_range(2_000_000);
            2:       return $urandom_range(200_000_000);
            default: return $urandom;
        endcase
    endfunction

    // ---------------------------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------------------------
    // Report on a never-used channel and stop without a preceding start
    task automatic test_empty_and_orphan_stop();
        send_item(OP_REPORT, CH_FEATURE, 32'h0);
        send_item(OP_STOP, CH_INFER, 32'd1000);      // start stamp still at reset zero
        send_item(OP_REPORT, CH_INFER, 32'hFFFF_FFFF);
    endtask

    // Counter wraparound, full-range span, zero span, then reports with samples
    task automatic test_wraparound_extremes();
        send_item(OP_START, CH_FEATURE, 32'hFFFF_FFF0);
        send_item(OP_STOP, CH_FEATURE, 32'h0000_0010);
        send_item(OP_START, TOTAL_CHANNEL, 32'h0);
        send_item(OP_STOP, TOTAL_CHANNEL, 32'hFFFF_FFFF);
        send_item(OP_START, CH_FEATURE, 32'h5555_5555);
        send_item(OP_STOP, CH_FEATURE, 32'h5555_5555);
        send_item(OP_START, CH_INFER, 32'hAAAA_AAAA);
        send_item(OP_STOP, CH_INFER, 32'h2AAA_AAAA);
        send_item(OP_REPORT, CH_FEATURE, 32'h0);
        send_item(OP_REPORT, CH_INFER, 32'h0);
        send_item(OP_REPORT, TOTAL_CHANNEL, 32'h0);
    endtask

    // Channel past the last is ignored; clear with any channel wipes all statistics but keeps start stamps
    task automatic test_bad_channel_and_clear();
        send_item(OP_START, BAD_CHANNEL, 32'h1234_5678);
        send_item(OP_STOP, BAD_CHANNEL, 32'hFFFF_FFFF);
        send_item(OP_REPORT, BAD_CHANNEL, 32'h0);
        send_item(OP_STOP, TOTAL_CHANNEL, 32'h0100_0000);
        send_item(OP_CLEAR, BAD_CHANNEL, 32'hFFFF_FFFF);
        send_item(OP_REPORT, CH_FEATURE, 32'h0);     // mean back to zero after clear
        send_item(OP_REPORT, TOTAL_CHANNEL, 32'h0);
        send_item(OP_STOP, TOTAL_CHANNEL, 32'h0200_0000);
    endtask

    // Divisor at one, at its top value, and at zero
    task automatic test_clock_extremes();
        write_clock_mhz(10'd1);
        send_item(OP_START, CH_FEATURE, 32'h0);
        send_item(OP_STOP, CH_FEATURE, 32'hFFFF_FFFF);
        send_item(OP_REPORT, CH_FEATURE, 32'h0);
        write_clock_mhz(10'd1023);
        send_item(OP_STOP, CH_INFER, 32'hFFFF_FFFF);
        send_item(OP_STOP, CH_INFER, 32'h0000_03FE);
        write_clock_mhz(10'd0);
        send_item(OP_STOP, TOTAL_CHANNEL, 32'hDEAD_BEEF);
        send_item(OP_REPORT, TOTAL_CHANNEL, 32'h0);
    endtask

    // Mostly well-formed profiling sequences with random stamps, plus noise
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned        done;
        int unsigned        pick;
        logic [CHAN_W-1:0]  ch;
        logic [STAMP_W-1:0] t;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(99);
            t    = $urandom;
            ch   = CHAN_W'($urandom_range(NUM_CH - 1));
            if (pick < 40) begin
                // one measurement, sometimes followed by a report
                send_item(OP_START, ch, t);
                send_item(OP_STOP, ch, t + random_span());
                done += 2;
                if ($urandom_range(3) == 0) begin
                    send_item(OP_REPORT, ch, $urandom);
                    done++;
                end
            end else if (pick < 65) begin
                // nested frame: total wraps feature extract and inference
                send_item(OP_START, TOTAL_CHANNEL, t);
                t = t + random_span();
                send_item(OP_START, CH_FEATURE, t);
                t = t + random_span();
                send_item(OP_STOP, CH_FEATURE, t);
                send_item(OP_START, CH_INFER, t);
                t = t + random_span();
                send_item(OP_STOP, CH_INFER, t);
                send_item(OP_STOP, TOTAL_CHANNEL, t + random_span());
                done += 6;
            end else if (pick < 80) begin
                send_item(OP_REPORT, ch, t);
                done++;
            end else if (pick < 88) begin
                send_item(OP_STOP, ch, t);           // stop against an old start
                done++;
            end else if (pick < 93) begin
                send_item(OP_START, ch, t);
                done++;
            end else if (pick < 97) begin
                // ignored by the block, so not counted
                send_item(OP_W'($urandom_range(OP_REPORT)), BAD_CHANNEL, t);
            end else begin
                send_item(OP_CLEAR, CHAN_W'($urandom_range(3)), t);
                done++;
            end
        end
    endtask

    // Stall the receiver for a long stretch while stops keep coming
    task automatic test_output_backpressure();
        logic [STAMP_W-1:0] t;
        fork
            hold_receiver(HOLD_CYCLES);
        join_none
        for (int k = 0; k < 12; k++) begin
            t = $urandom;
            send_item(OP_START, TOTAL_CHANNEL, t);
            send_item(OP_STOP, TOTAL_CHANNEL, t + random_span());
            send_item(OP_REPORT, TOTAL_CHANNEL, $urandom);
        end
    endtask

    // ---------------------------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------------------------
    initial begin
        // hold every input at a known value from time zero
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_operation     = OP_START;
        i_channel       = CH_FEATURE;
        i_cycle_stamp   = '0;
        i_out_ready     = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_clock_mhz = CLOCK_MHZ_RESET;
        rx_hold         = 1'b0;
        cycle_count     = 0;
        mismatches      = 0;
        items_sent      = 0;
        stop_results    = 0;
        report_results  = 0;
        cfg_writes      = 0;
        send_idle_pct   = 24;
        recv_idle_pct   = 87;

        // initialise the predictor to the reset state
        st_clock_mhz = CLOCK_MHZ_RESET;
        for (int c = 0; c < NUM_CH; c++) st_start[c] = '0;
        clear_model_stats();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_orphan_stop();
        test_wraparound_extremes();
        test_bad_channel_and_clear();
        test_clock_extremes();

        // phase one: sender idles a little, receiver a lot
        write_clock_mhz(CLK_MHZ_W'($urandom_range(1023, 1)));
        test_random_traffic(560);

        // phase two: the other way round, with a 1 MHz clock for large statistics
        write_clock_mhz(10'd1);
        send_idle_pct = 87;
        recv_idle_pct = 24;
        test_random_traffic(560);

        // phase three: no idling, and one long receiver stall
        write_clock_mhz(CLOCK_MHZ_RESET);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_backpressure();
        test_random_traffic(560);

        settle_block();
        $display("Sent %0d items; checked %0d stop results and %0d reports",
                 items_sent, stop_results, report_results);
        $display("Clock settings written: %0d, incl. 0, 1 and 1023; %0d cycles, %0d mismatches",
                 cfg_writes, cycle_count, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
